>>> hdl/fprc_pkg.sv
// Package with the types and constants shared by the framed packet receive checker.
`timescale 1ns / 1ps
`default_nettype none

package fprc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 9;
  localparam int unsigned CfgIdxW = 8;

  // Start marker and length byte come before the payload.
  localparam logic [PosW-1:0] HeaderLen = PosW'(2);
  // Header plus checksum and end marker.
  localparam logic [PosW-1:0] FrameOverhead = PosW'(4);

  localparam logic [ByteW-1:0] StartMarkerRst = ByteW'(2);
  localparam logic [ByteW-1:0] EndMarkerRst   = ByteW'(3);

  typedef enum logic [CfgIdxW-1:0] {
    RegStartMarker = CfgIdxW'(0),
    RegEndMarker   = CfgIdxW'(1)
  } cfg_reg_e;

  typedef enum logic [1:0] {
    VerdictOk       = 2'd0,
    VerdictBadStart = 2'd1,
    VerdictBadSum   = 2'd2,
    VerdictBadEnd   = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [ByteW-1:0] echoed_byte;
    logic [PosW-1:0]  byte_position;
    verdict_e         verdict;
    logic             packet_complete;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/fprc_intf.sv
// Handshake interfaces for the byte input, the result output and the register write port.
`timescale 1ns / 1ps
`default_nettype none

interface fprc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fprc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] echoed_byte;
  logic [8:0] byte_position;
  logic [1:0] verdict;
  logic       packet_complete;

  modport source (output valid, output echoed_byte, output byte_position, output verdict,
                  output packet_complete, input ready);
  modport sink (input valid, input echoed_byte, input byte_position, input verdict,
                input packet_complete, output ready);
endinterface

interface fprc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/fprc_frame_check.sv
// Framing state and per-byte verdict logic of the packet checker.
`timescale 1ns / 1ps
`default_nettype none

module fprc_frame_check
  import fprc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [ByteW-1:0] rx_byte_i,
  input  wire logic [ByteW-1:0] start_marker_i,
  input  wire logic [ByteW-1:0] end_marker_i,
  output result_t               result_o
);

  logic [PosW-1:0]  bytes_seen_q, bytes_seen_d;
  logic [PosW-1:0]  expected_total_q, expected_total_d;
  logic [ByteW-1:0] running_xor_q, running_xor_d;

  logic [PosW:0]    size;
  logic [PosW-1:0]  expected_m1;
  verdict_e         verdict;
  logic             complete;

  assign size        = {1'b0, bytes_seen_q} + (PosW+1)'(1);
  assign expected_m1 = expected_total_q - PosW'(1);

  always_comb begin
    bytes_seen_d     = bytes_seen_q;
    expected_total_d = expected_total_q;
    running_xor_d    = running_xor_q;
    verdict          = VerdictOk;
    complete         = 1'b0;

    if (bytes_seen_q == '0) begin
      bytes_seen_d     = '0;
      expected_total_d = '0;
      running_xor_d    = '0;
      if (rx_byte_i == start_marker_i) begin
        bytes_seen_d     = PosW'(1);
        expected_total_d = HeaderLen;
      end else begin
        verdict = VerdictBadStart;
      end
    end else if (bytes_seen_q == PosW'(1)) begin
      // The length byte fixes the full frame size.
      expected_total_d = PosW'(rx_byte_i) + FrameOverhead;
      bytes_seen_d     = PosW'(2);
    end else if (size == {1'b0, expected_total_q}) begin
      if (rx_byte_i == end_marker_i) begin
        complete = 1'b1;
      end else begin
        verdict = VerdictBadEnd;
      end
      bytes_seen_d     = '0;
      expected_total_d = '0;
      running_xor_d    = '0;
    end else if (size == {1'b0, expected_m1}) begin
      if (rx_byte_i != running_xor_q) begin
        verdict          = VerdictBadSum;
        bytes_seen_d     = '0;
        expected_total_d = '0;
        running_xor_d    = '0;
      end else begin
        bytes_seen_d = size[PosW-1:0];
      end
    end else begin
      running_xor_d = running_xor_q ^ rx_byte_i;
      bytes_seen_d  = size[PosW-1:0];
    end
  end

  always_comb begin
    result_o.echoed_byte     = rx_byte_i;
    result_o.byte_position   = bytes_seen_q;
    result_o.verdict         = verdict;
    result_o.packet_complete = complete;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q     <= '0;
      expected_total_q <= '0;
      running_xor_q    <= '0;
    end else if (accept_i) begin
      bytes_seen_q     <= bytes_seen_d;
      expected_total_q <= expected_total_d;
      running_xor_q    <= running_xor_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/fprc_out_skid.sv
// Result register with a skid entry so the input side keeps running while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module fprc_out_skid
  import fprc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire result_t in_data_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  output result_t      out_data_o,
  input  wire logic    out_ready_i
);

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    in_take;

  assign in_ready_o  = !skid_valid_q;
  assign in_take     = in_valid_i && !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !main_valid_q) begin
      main_valid_q <= skid_valid_q || in_take;
      skid_valid_q <= 1'b0;
    end else if (in_take) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !main_valid_q) begin
      main_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (in_take) begin
      skid_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/framed_packet_receive_checker_core.sv
// Top level of the framed packet receive checker: registers, framing check and result buffer.
//
//   channel  role        payload                                            notes
//   rx       sink        rx_byte                                            one word per byte
//   res      source      echoed_byte, byte_position, verdict, packet_complete one per byte
//   cfg      sink        index, data                                        always ready
//
// Every byte word yields one result word, which is registered in the result buffer when the byte is accepted.
// A byte can be accepted in every cycle while the skid entry is free; the framing state updates in the same cycle.
// Reset clears the framing state and loads the marker registers with their defaults.
// A stalled result sits in the output register and a second one in the skid entry;
// rx ready drops only while the skid entry is occupied.
`timescale 1ns / 1ps
`default_nettype none

module framed_packet_receive_checker_core
  import fprc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fprc_rx_if.sink   rx,
  fprc_res_if.source res,
  fprc_cfg_if.sink  cfg
);

  logic [ByteW-1:0] start_marker_q;
  logic [ByteW-1:0] end_marker_q;
  logic             rx_ready;
  logic             rx_accept;
  result_t          check_result;
  result_t          out_result;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= StartMarkerRst;
      end_marker_q   <= EndMarkerRst;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        RegStartMarker: start_marker_q <= cfg.data;
        RegEndMarker:   end_marker_q   <= cfg.data;
        default: ;
      endcase
    end
  end

  assign rx.ready  = rx_ready;
  assign rx_accept = rx.valid && rx_ready;

  fprc_frame_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (rx_accept),
    .rx_byte_i     (rx.rx_byte),
    .start_marker_i(start_marker_q),
    .end_marker_i  (end_marker_q),
    .result_o      (check_result)
  );

  fprc_out_skid u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx.valid),
    .in_data_i  (check_result),
    .in_ready_o (rx_ready),
    .out_valid_o(res.valid),
    .out_data_o (out_result),
    .out_ready_i(res.ready)
  );

  assign res.echoed_byte     = out_result.echoed_byte;
  assign res.byte_position   = out_result.byte_position;
  assign res.verdict         = out_result.verdict;
  assign res.packet_complete = out_result.packet_complete;

endmodule

`default_nettype wire
